>>> rtl/core/ctp_pkg.sv
// Shared constants, types and the arctangent table of the Cartesian-to-polar unit.
`default_nettype none

package ctp_pkg;

    // Default sizes handed to the top level.
    localparam int COORD_WIDTH_DEFAULT  = 16;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    // Fixed formats of the datapath and of the result fields.
    localparam int FRAC_BITS   = 16;
    localparam int MAG_WIDTH   = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int ACC_WIDTH   = 32;
    localparam int GAIN_WIDTH  = 32;

    localparam logic [GAIN_WIDTH-1:0]  INV_GAIN           = 32'h9B74_EDA8;
    localparam logic [ACC_WIDTH-1:0]   HALF_TURN_ACC      = 32'h8000_0000;
    localparam logic [ACC_WIDTH-1:0]   ANGLE_ROUND        = 32'h0000_8000;
    localparam logic [ANGLE_WIDTH-1:0] ZERO_TURN          = 16'd0;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN       = 16'd16384;
    localparam logic [ANGLE_WIDTH-1:0] THREE_QUARTER_TURN = 16'd49152;
    localparam logic [MAG_WIDTH-1:0]   MAG_MAX            = 16'hFFFF;

    // Side information that travels with each request through the pipeline.
    // A point on the y axis or the origin bypasses the rotations; its final
    // result is settled at the input and only selected at the output.
    typedef struct packed {
        logic                   bypass;
        logic                   defined;
        logic [MAG_WIDTH-1:0]   mag;
        logic [ANGLE_WIDTH-1:0] ang;
    } ctp_side_t;

    // Arctangent of 2^-idx in units of 2^-32 turn, rounded.
    function automatic logic [ACC_WIDTH-1:0] atan_turn(input logic [4:0] idx);
        logic [ACC_WIDTH-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            5'd24:   val = 32'h0000_0029;
            5'd25:   val = 32'h0000_0014;
            5'd26:   val = 32'h0000_000A;
            5'd27:   val = 32'h0000_0005;
            5'd28:   val = 32'h0000_0003;
            5'd29:   val = 32'h0000_0001;
            5'd30:   val = 32'h0000_0001;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ctp_point_if.sv
// Valid/ready channel that carries one Cartesian point.
`default_nettype none

interface ctp_point_if
    import ctp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] coord_x;
    logic [COORD_WIDTH-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ctp_polar_if.sv
// Valid/ready channel that carries one polar result.
`default_nettype none

interface ctp_polar_if
    import ctp_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [MAG_WIDTH-1:0]   magnitude;
    logic [ANGLE_WIDTH-1:0] angle;
    logic                   angle_defined;

    modport source (output valid, output magnitude, output angle, output angle_defined,
                    input ready);
    modport sink   (input valid, input magnitude, input angle, input angle_defined,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/cartesian_to_polar_unit.sv
// Top level of the pipelined CORDIC Cartesian-to-polar converter.
//
// Requests arrive on the point channel (valid/ready, coord_x and coord_y as
// two's complement integers of COORD_WIDTH bits). Each one leaves exactly one
// result on the polar channel: the rounded, gain-corrected radius saturated at
// 16 bits, the angle in 65536 units per turn, and angle_defined, which is low
// only for the origin. Results leave in request order.
// The pipeline holds one input stage, one register per micro-rotation, one
// stage for the gain partial products and the output register. Throughput is
// one request per cycle while the receiver takes results; every stage holds a
// valid bit and a register, so that figure is set by the unrolled rotation
// chain. When the receiver stalls, the output register holds its result and
// the stall reaches back through the combinational ready chain: empty stages
// keep filling, and point.ready falls only once every stage holds a request.
// Reset clears all valid bits; the pipeline then starts empty.
`default_nettype none

module cartesian_to_polar_unit
    import ctp_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctp_point_if.sink  point,
    ctp_polar_if.source polar
);

    // Radius grows by the CORDIC gain and up to the square root of two.
    localparam int DW = COORD_WIDTH + FRAC_BITS + 3;

    logic                 valid_s [0:CORDIC_STEPS];
    logic                 ready_s [0:CORDIC_STEPS];
    logic signed [DW-1:0] x_s     [0:CORDIC_STEPS];
    logic signed [DW-1:0] y_s     [0:CORDIC_STEPS];
    logic [ACC_WIDTH-1:0] acc_s   [0:CORDIC_STEPS];
    ctp_side_t            side_s  [0:CORDIC_STEPS];

    // Input stage.
    ctp_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .DW          (DW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_valid (point.valid),
        .pt_ready (point.ready),
        .coord_x  (point.coord_x),
        .coord_y  (point.coord_y),
        .st_valid (valid_s[0]),
        .st_ready (ready_s[0]),
        .st_x     (x_s[0]),
        .st_y     (y_s[0]),
        .st_acc   (acc_s[0]),
        .st_side  (side_s[0])
    );

    // Chain of micro-rotations, one register stage each.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        ctp_cordic_stage #(
            .DW   (DW),
            .STEP (i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .prev_valid (valid_s[i]),
            .prev_ready (ready_s[i]),
            .prev_x     (x_s[i]),
            .prev_y     (y_s[i]),
            .prev_acc   (acc_s[i]),
            .prev_side  (side_s[i]),
            .next_valid (valid_s[i+1]),
            .next_ready (ready_s[i+1]),
            .next_x     (x_s[i+1]),
            .next_y     (y_s[i+1]),
            .next_acc   (acc_s[i+1]),
            .next_side  (side_s[i+1])
        );
    end

    // Gain correction and output register.
    ctp_gain #(
        .DW (DW)
    ) u_gain (
        .clk           (clk),
        .rst_n         (rst_n),
        .prev_valid    (valid_s[CORDIC_STEPS]),
        .prev_ready    (ready_s[CORDIC_STEPS]),
        .prev_x        (x_s[CORDIC_STEPS]),
        .prev_acc      (acc_s[CORDIC_STEPS]),
        .prev_side     (side_s[CORDIC_STEPS]),
        .res_valid     (polar.valid),
        .res_ready     (polar.ready),
        .magnitude     (polar.magnitude),
        .angle         (polar.angle),
        .angle_defined (polar.angle_defined)
    );

endmodule

`default_nettype wire

>>> rtl/core/ctp_prep.sv
// Input stage: axis and origin detection, half-turn pre-rotation and scaling.
`default_nettype none

module ctp_prep
    import ctp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
    parameter int DW          = COORD_WIDTH + FRAC_BITS + 3
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pt_valid,
    output      logic                   pt_ready,
    input  wire logic [COORD_WIDTH-1:0] coord_x,
    input  wire logic [COORD_WIDTH-1:0] coord_y,
    output      logic                   st_valid,
    input  wire logic                   st_ready,
    output      logic signed [DW-1:0]   st_x,
    output      logic signed [DW-1:0]   st_y,
    output      logic [ACC_WIDTH-1:0]   st_acc,
    output      ctp_side_t              st_side
);

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    ctp_side_t            side_reg, side_next;

    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [DW-1:0] abs_y;
    logic                 x_zero;
    logic                 y_zero;

    assign xs     = DW'($signed(coord_x));
    assign ys     = DW'($signed(coord_y));
    assign x_zero = (coord_x == '0);
    assign y_zero = (coord_y == '0);
    assign abs_y  = ys[DW-1] ? -ys : ys;

    // Turn left-half-plane points by half a turn, then move to the fraction format.
    always_comb
    begin
        if (xs[DW-1])
        begin
            x_next   = (-xs) <<< FRAC_BITS;
            y_next   = (-ys) <<< FRAC_BITS;
            acc_next = HALF_TURN_ACC;
        end
        else
        begin
            x_next   = xs <<< FRAC_BITS;
            y_next   = ys <<< FRAC_BITS;
            acc_next = '0;
        end
    end

    // Result of a point on the y axis or the origin, settled here.
    always_comb
    begin
        side_next.bypass  = x_zero;
        side_next.defined = !(x_zero && y_zero);
        if ($unsigned(abs_y) > DW'(MAG_MAX))
            side_next.mag = MAG_MAX;
        else
            side_next.mag = abs_y[MAG_WIDTH-1:0];
        if (y_zero)
            side_next.ang = ZERO_TURN;
        else if (ys[DW-1])
            side_next.ang = THREE_QUARTER_TURN;
        else
            side_next.ang = QUARTER_TURN;
    end

    // The stage takes a new request whenever it is empty or drains this cycle.
    assign pt_ready = !valid_reg || st_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pt_ready)
            valid_reg <= pt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pt_ready && pt_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= side_next;
        end
    end

    assign st_valid = valid_reg;
    assign st_x     = x_reg;
    assign st_y     = y_reg;
    assign st_acc   = acc_reg;
    assign st_side  = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/ctp_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation.
`default_nettype none

module ctp_cordic_stage
    import ctp_pkg::*;
#(
    parameter int DW   = COORD_WIDTH_DEFAULT + FRAC_BITS + 3,
    parameter int STEP = 0
)(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 prev_valid,
    output      logic                 prev_ready,
    input  wire logic signed [DW-1:0] prev_x,
    input  wire logic signed [DW-1:0] prev_y,
    input  wire logic [ACC_WIDTH-1:0] prev_acc,
    input  wire ctp_side_t            prev_side,
    output      logic                 next_valid,
    input  wire logic                 next_ready,
    output      logic signed [DW-1:0] next_x,
    output      logic signed [DW-1:0] next_y,
    output      logic [ACC_WIDTH-1:0] next_acc,
    output      ctp_side_t            next_side
);

    localparam logic [ACC_WIDTH-1:0] ATAN_STEP = atan_turn(5'(STEP));

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic [ACC_WIDTH-1:0] acc_reg, acc_next;
    ctp_side_t            side_reg;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    // Floor shifts of the two coordinates.
    assign dx = prev_y >>> STEP;
    assign dy = prev_x >>> STEP;

    // Rotate toward the x axis; the sign of y picks the direction.
    always_comb
    begin
        if (!prev_y[DW-1])
        begin
            x_next   = prev_x + dx;
            y_next   = prev_y - dy;
            acc_next = prev_acc + ATAN_STEP;
        end
        else
        begin
            x_next   = prev_x - dx;
            y_next   = prev_y + dy;
            acc_next = prev_acc - ATAN_STEP;
        end
    end

    assign prev_ready = !valid_reg || next_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (prev_ready)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (prev_ready && prev_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= prev_side;
        end
    end

    assign next_valid = valid_reg;
    assign next_x     = x_reg;
    assign next_y     = y_reg;
    assign next_acc   = acc_reg;
    assign next_side  = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/ctp_gain.sv
// Gain correction of the radius, angle rounding and the output register.
`default_nettype none

module ctp_gain
    import ctp_pkg::*;
#(
    parameter int DW = COORD_WIDTH_DEFAULT + FRAC_BITS + 3
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   prev_valid,
    output      logic                   prev_ready,
    input  wire logic signed [DW-1:0]   prev_x,
    input  wire logic [ACC_WIDTH-1:0]   prev_acc,
    input  wire ctp_side_t              prev_side,
    output      logic                   res_valid,
    input  wire logic                   res_ready,
    output      logic [MAG_WIDTH-1:0]   magnitude,
    output      logic [ANGLE_WIDTH-1:0] angle,
    output      logic                   angle_defined
);

    // The radius is split at bit 32 so that each multiplier operand stays at most 32 bits wide.
    localparam int GW = (DW > GAIN_WIDTH) ? DW : GAIN_WIDTH + 1;
    localparam int HW = GW - GAIN_WIDTH;
    localparam int QW = HW + GAIN_WIDTH + 1;

    logic [GW-1:0]              x_ext;
    logic [ACC_WIDTH-1:0]       acc_round;

    // First stage: the two partial products and the rounded angle.
    logic                       va_reg;
    logic [2*GAIN_WIDTH-1:0]    p_lo_reg;
    logic [HW+GAIN_WIDTH-1:0]   p_hi_reg;
    logic [ANGLE_WIDTH-1:0]     ang_a_reg;
    ctp_side_t                  side_a_reg;
    logic                       ready_a;

    // Second stage: the output register.
    logic                       vb_reg;
    logic [MAG_WIDTH-1:0]       mag_reg, mag_next;
    logic [ANGLE_WIDTH-1:0]     ang_reg, ang_next;
    logic                       def_reg;
    logic                       ready_b;

    logic [QW-1:0]              q;
    logic [QW-1:0]              q_round;
    logic [MAG_WIDTH-1:0]       mag_sat;

    assign x_ext     = GW'($unsigned(prev_x));
    assign acc_round = prev_acc + ANGLE_ROUND;

    assign ready_a    = !va_reg || ready_b;
    assign prev_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (ready_a)
            va_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && prev_valid)
        begin
            p_lo_reg   <= x_ext[GAIN_WIDTH-1:0] * INV_GAIN;
            p_hi_reg   <= x_ext[GW-1:GAIN_WIDTH] * INV_GAIN;
            ang_a_reg  <= acc_round[ACC_WIDTH-1:ACC_WIDTH-ANGLE_WIDTH];
            side_a_reg <= prev_side;
        end
    end

    // Sum of the products, rounding to an integer and saturation.
    assign q       = QW'(p_hi_reg) + QW'(p_lo_reg[2*GAIN_WIDTH-1:GAIN_WIDTH]);
    assign q_round = q + QW'(1 << (FRAC_BITS - 1));
    assign mag_sat = (|q_round[QW-1:FRAC_BITS+MAG_WIDTH]) ? MAG_MAX
                                                          : q_round[FRAC_BITS+MAG_WIDTH-1:FRAC_BITS];

    // Points on the y axis and the origin take the result settled at the input.
    always_comb
    begin
        if (side_a_reg.bypass)
        begin
            mag_next = side_a_reg.mag;
            ang_next = side_a_reg.ang;
        end
        else
        begin
            mag_next = mag_sat;
            ang_next = ang_a_reg;
        end
    end

    assign ready_b = !vb_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (ready_b)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && va_reg)
        begin
            mag_reg <= mag_next;
            ang_reg <= ang_next;
            def_reg <= side_a_reg.defined;
        end
    end

    assign res_valid     = vb_reg;
    assign magnitude     = mag_reg;
    assign angle         = ang_reg;
    assign angle_defined = def_reg;

endmodule

`default_nettype wire

>>> rtl/core/ctp_checker.sv
// Port-level checks of the Cartesian-to-polar unit and their binding.
`default_nettype none

module ctp_checker
    import ctp_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   res_valid,
    input wire logic                   res_ready,
    input wire logic [MAG_WIDTH-1:0]   magnitude,
    input wire logic [ANGLE_WIDTH-1:0] angle,
    input wire logic                   angle_defined
);

    localparam int DEPTH = CORDIC_STEPS + 3;
    localparam int CW    = $clog2(DEPTH + 2) + 1;

    logic          in_fire;
    logic          res_fire;
    logic [CW-1:0] count_reg, count_next;

    assign in_fire  = in_valid && in_ready;
    assign res_fire = res_valid && res_ready;

    // Requests accepted whose results have not yet been taken.
    always_comb
    begin
        count_next = count_reg;
        if (in_fire && !res_fire)
            count_next = count_reg + CW'(1);
        else if (res_fire && !in_fire)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(magnitude) && $stable(angle)
            && $stable(angle_defined))
        else $error("stalled result changed or was dropped");

    // A result is only offered for a request that was accepted earlier.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> count_reg != '0)
        else $error("result offered without an outstanding request");

    // The pipeline never holds more requests than it has stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("more requests in flight than pipeline stages");

    // The origin gives a zero radius and a zero angle.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !angle_defined |-> magnitude == '0 && angle == '0)
        else $error("undefined angle with nonzero fields");

endmodule

bind cartesian_to_polar_unit ctp_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_ctp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (point.valid),
    .in_ready      (point.ready),
    .res_valid     (polar.valid),
    .res_ready     (polar.ready),
    .magnitude     (polar.magnitude),
    .angle         (polar.angle),
    .angle_defined (polar.angle_defined)
);

`default_nettype wire
